@@ rtl/bf3_pkg.sv @@
// Shared constants, types and helpers of the 3x3 box filter.
`timescale 1ns / 1ps
`default_nettype none
package bf3_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int PIXEL_BITS = 16;

  // Column and row counters, and the clamped frame sizes.
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int WEFF_W = COL_W + 1;
  localparam int HEFF_W = ROW_W + 1;

  // Size register fields as seen on the configuration port.
  localparam int WREG_W = 11;
  localparam int HREG_W = 13;
  localparam logic [WREG_W-1:0] FRAME_WIDTH_RST  = WREG_W'(1024);
  localparam logic [HREG_W-1:0] FRAME_HEIGHT_RST = HREG_W'(1024);

  // Item kinds.
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // Column sum of three pixels, sum of nine pixels, magnitude of that sum.
  localparam int CS_W  = PIXEL_BITS + 2;
  localparam int SUM_W = PIXEL_BITS + 4;
  localparam int MAG_W = PIXEL_BITS + 3;

  // Division by nine as a multiplication by a rounded-up reciprocal. The
  // rounding error stays below the weight of one quotient step for every
  // magnitude below 2**MAG_W.
  localparam int DIV9_SHIFT = MAG_W + 4;
  localparam int MULT_W     = MAG_W + 1;
  localparam int PROD_W     = MAG_W + MULT_W;
  localparam logic [MULT_W-1:0] DIV9_MULT =
    MULT_W'(((64'd1 << DIV9_SHIFT) + 64'd8) / 64'd9);

  // Queue between the front and the back; the depth is a power of two.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // One result to be produced. A mean result adds the three column sums
  // and divides by nine; any other result carries its pixel in s0.
  typedef struct packed {
    logic                   mean;
    logic                   last;
    logic signed [CS_W-1:0] s0;
    logic signed [CS_W-1:0] s1;
    logic signed [CS_W-1:0] s2;
  } work_t;

  function automatic logic signed [CS_W-1:0] sext_cs(
    input logic signed [PIXEL_BITS-1:0] v
  );
    return {{(CS_W - PIXEL_BITS){v[PIXEL_BITS-1]}}, v};
  endfunction

endpackage
`default_nettype wire

@@ rtl/bf3_front.sv @@
// Front of the box filter: item intake, frame position, line stores and window.
`timescale 1ns / 1ps
`default_nettype none
module bf3_front import bf3_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_clear,
  input  logic [WEFF_W-1:0]            width_eff,
  input  logic [HEFF_W-1:0]            height_eff,
  input  logic                         item_valid,
  output logic                         item_ready,
  input  logic                         opcode,
  input  logic signed [PIXEL_BITS-1:0] pixel_in,
  input  logic                         queue_full,
  output logic                         work_push,
  output work_t                        work
);

  logic [COL_W-1:0] col_last;
  logic [ROW_W-1:0] row_last;

  // Frame position.
  logic [COL_W-1:0] in_col, in_col_next;
  logic [ROW_W-1:0] in_row, in_row_next;
  logic [COL_W-1:0] out_col, out_col_next;
  logic [ROW_W-1:0] out_row, out_row_next;
  logic             in_done, in_done_next;

  // Intake classification.
  logic             accept;
  logic             issue;
  logic             f0_pix;
  logic             f0_emit;
  logic             f0_interior;
  logic             f0_last;
  logic             f0_selb;
  logic [COL_W-1:0] f0_addr;
  logic             at_out_last;
  logic             fwd_hit;

  // Line stores: the upper half of a word is the row two above, the lower
  // half the row just above.
  logic [2*PIXEL_BITS-1:0] line_mem [MAX_WIDTH];
  logic [2*PIXEL_BITS-1:0] mem_q;

  // Second stage.
  logic                         f1_valid;
  logic                         f1_pix;
  logic                         f1_emit;
  logic                         f1_interior;
  logic                         f1_last;
  logic                         f1_selb;
  logic [COL_W-1:0]             f1_addr;
  logic signed [PIXEL_BITS-1:0] f1_p;
  logic                         f1_fwd;
  logic signed [PIXEL_BITS-1:0] f1_fwd_top;
  logic signed [PIXEL_BITS-1:0] f1_fwd_mid;
  logic                         f1_go;
  logic signed [PIXEL_BITS-1:0] top_v;
  logic signed [PIXEL_BITS-1:0] mid_v;
  logic signed [CS_W-1:0]       new_cs;

  // Window: the two newer column sums and the center pixel.
  logic signed [CS_W-1:0]       cs_a;
  logic signed [CS_W-1:0]       cs_b;
  logic signed [PIXEL_BITS-1:0] ctr;

  assign col_last = COL_W'(width_eff - 1'b1);
  assign row_last = ROW_W'(height_eff - 1'b1);

  assign f1_go      = f1_valid && (!f1_emit || !queue_full);
  assign item_ready = !f1_valid || f1_go;
  assign accept     = item_valid && item_ready;
  assign at_out_last = (out_row == row_last) && (out_col == col_last);

  always_comb begin
    in_col_next  = in_col;
    in_row_next  = in_row;
    out_col_next = out_col;
    out_row_next = out_row;
    in_done_next = in_done;
    issue        = 1'b0;
    f0_pix       = 1'b0;
    f0_emit      = 1'b0;
    f0_interior  = 1'b0;
    f0_last      = 1'b0;
    f0_selb      = 1'b0;
    f0_addr      = in_col;
    if (accept) begin
      if (opcode == OP_PIXEL) begin
        if (!in_done) begin
          issue   = 1'b1;
          f0_pix  = 1'b1;
          f0_emit = (in_row > ROW_W'(1)) || ((in_row == ROW_W'(1)) && (in_col != '0));
          if (in_col == col_last) begin
            in_col_next = '0;
            if (in_row == row_last) begin
              in_row_next  = '0;
              in_done_next = 1'b1;
            end else begin
              in_row_next = in_row + 1'b1;
            end
          end else begin
            in_col_next = in_col + 1'b1;
          end
          f0_interior = (out_row != '0) && (out_row != row_last) &&
                        (out_col != '0) && (out_col != col_last);
        end
      end else if (in_done) begin
        issue   = 1'b1;
        f0_emit = 1'b1;
        f0_addr = out_col;
        f0_selb = (out_row == row_last);
      end
      if (f0_emit) begin
        f0_last = at_out_last;
        if (out_col == col_last) begin
          out_col_next = '0;
          out_row_next = out_row + 1'b1;
        end else begin
          out_col_next = out_col + 1'b1;
        end
        // The final result of the frame rewinds every position counter.
        if (at_out_last) begin
          in_col_next  = '0;
          in_row_next  = '0;
          out_col_next = '0;
          out_row_next = '0;
          in_done_next = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_clear) begin
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
      in_done <= 1'b0;
    end else begin
      in_col  <= in_col_next;
      in_row  <= in_row_next;
      out_col <= out_col_next;
      out_row <= out_row_next;
      in_done <= in_done_next;
    end
  end

  // A pixel in the second stage writes the entry that the new item reads in
  // the same cycle; the new item then takes the written word directly.
  assign fwd_hit = f1_valid && f1_pix && (f1_addr == f0_addr);

  always_ff @(posedge clk) begin
    if (f1_go && f1_pix) begin
      line_mem[f1_addr] <= {mid_v, f1_p};
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      mem_q <= line_mem[f0_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else if (item_ready) begin
      f1_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready) begin
      f1_pix      <= f0_pix;
      f1_emit     <= f0_emit;
      f1_interior <= f0_interior;
      f1_last     <= f0_last;
      f1_selb     <= f0_selb;
      f1_addr     <= f0_addr;
      f1_p        <= pixel_in;
      f1_fwd      <= fwd_hit;
      f1_fwd_top  <= mid_v;
      f1_fwd_mid  <= f1_p;
    end
  end

  assign top_v  = f1_fwd ? f1_fwd_top : mem_q[2*PIXEL_BITS-1:PIXEL_BITS];
  assign mid_v  = f1_fwd ? f1_fwd_mid : mem_q[PIXEL_BITS-1:0];
  assign new_cs = sext_cs(top_v) + sext_cs(mid_v) + sext_cs(f1_p);

  always_ff @(posedge clk) begin
    if (rst) begin
      cs_a <= '0;
      cs_b <= '0;
      ctr  <= '0;
    end else if (f1_go && f1_pix) begin
      cs_a <= cs_b;
      cs_b <= new_cs;
      ctr  <= mid_v;
    end
  end

  always_comb begin
    work.mean = f1_interior;
    work.last = f1_last;
    work.s1   = '0;
    work.s2   = '0;
    if (f1_pix) begin
      if (f1_interior) begin
        work.s0 = cs_a;
        work.s1 = cs_b;
        work.s2 = new_cs;
      end else begin
        work.s0 = sext_cs(ctr);
      end
    end else begin
      work.s0 = sext_cs(f1_selb ? mid_v : top_v);
    end
  end

  assign work_push = f1_go && f1_emit;

  a_done_rewound: assert property (@(posedge clk) disable iff (rst)
    in_done |-> (in_col == '0) && (in_row == '0))
    else $error("input position not rewound after the last pixel");

  a_intake_moves_stage: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready && f1_valid) |-> f1_go)
    else $error("item taken while the second stage is held");

endmodule
`default_nettype wire

@@ rtl/bf3_queue.sv @@
// Small result queue between the front and the back of the box filter.
`timescale 1ns / 1ps
`default_nettype none
module bf3_queue import bf3_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  work_t push_data,
  input  logic  pop,
  output work_t head,
  output logic  full,
  output logic  nonempty
);

  work_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full     = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign nonempty = (count != '0);
  assign head     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("queue read while empty");

endmodule
`default_nettype wire

@@ rtl/bf3_back.sv @@
// Back of the box filter: nine-pixel sum, division by nine and output register.
`timescale 1ns / 1ps
`default_nettype none
module bf3_back import bf3_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         work_valid,
  input  work_t                        work,
  output logic                         work_ready,
  output logic                         result_valid,
  input  logic                         result_ready,
  output logic signed [PIXEL_BITS-1:0] pixel_out,
  output logic                         frame_last
);

  logic                    out_take;
  logic                    b_free;
  logic                    a_free;

  logic                    a_valid;
  logic                    a_mean;
  logic                    a_last;
  logic signed [SUM_W-1:0] a_sum;

  logic                    a_neg;
  logic [SUM_W-1:0]        mag_full;
  logic [MAG_W-1:0]        mag;
  logic [PROD_W-1:0]       prod;

  logic                    b_valid;
  logic                    b_mean;
  logic                    b_last;
  logic                    b_neg;
  logic [PIXEL_BITS-1:0]   b_quo;
  logic [PIXEL_BITS-1:0]   b_pass;

  assign out_take   = !result_valid || result_ready;
  assign b_free     = !b_valid || out_take;
  assign a_free     = !a_valid || b_free;
  assign work_ready = a_free;

  // Stage a: add the three column sums.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_free) begin
      a_valid <= work_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_free) begin
      a_mean <= work.mean;
      a_last <= work.last;
      a_sum  <= {{(SUM_W - CS_W){work.s0[CS_W-1]}}, work.s0} +
                {{(SUM_W - CS_W){work.s1[CS_W-1]}}, work.s1} +
                {{(SUM_W - CS_W){work.s2[CS_W-1]}}, work.s2};
    end
  end

  // Stage b: divide the magnitude by nine; the sign is put back afterwards,
  // which truncates the quotient toward zero.
  assign a_neg    = a_sum[SUM_W-1];
  assign mag_full = a_neg ? -a_sum : a_sum;
  assign mag      = mag_full[MAG_W-1:0];
  assign prod     = PROD_W'(mag) * PROD_W'(DIV9_MULT);

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_free) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_free) begin
      b_mean <= a_mean;
      b_last <= a_last;
      b_neg  <= a_neg;
      b_quo  <= prod[DIV9_SHIFT +: PIXEL_BITS];
      b_pass <= a_sum[PIXEL_BITS-1:0];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_take) begin
      result_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take) begin
      pixel_out  <= b_mean ? (b_neg ? -b_quo : b_quo) : b_pass;
      frame_last <= b_last;
    end
  end

  a_div_holds: assert property (@(posedge clk) disable iff (rst)
    (b_valid && !out_take) |=> b_valid && $stable(b_quo) && $stable(b_neg))
    else $error("divider stage lost its value under stall");

endmodule
`default_nettype wire

@@ rtl/box_filter_3x3_unit.sv @@
// Top level of the streaming 3x3 box filter with its size registers.
`timescale 1ns / 1ps
`default_nettype none
// Streaming 3x3 mean filter over a raster frame of signed 16-bit pixels.
// Pixel items (opcode 0) and flush items (opcode 1) enter through the
// item_valid / item_ready channel; results leave through result_valid /
// result_ready with pixel_out and frame_last. A transfer happens on a clock
// edge where valid and ready of that channel are both high.
// Interior pixels become the sum of their 3x3 neighborhood divided by nine,
// truncated toward zero; pixels of the first and last row and column pass
// unchanged. The result for pixel i is caused by the transfer of pixel
// i + width + 1; after the last pixel of a frame, each flush item drains
// one more result, and the final one carries frame_last.
// Throughput is one item per cycle while item_ready is high: the line store
// is a one-read, one-write memory touched once per item, and the divider is
// a pipelined reciprocal multiply. Work passes the second front stage, a
// queue slot, stages a, b and the output register. A four-entry queue sits
// between the intake and the arithmetic, so the intake keeps taking items
// while result_ready is low until the queue fills; then item_ready drops.
// Reset clears the frame position and the window and sets both sizes to
// 1024; the line stores are not cleared and need no clearing pass. Writing
// frame_width (address 0) or frame_height (address 4) restarts the frame.
module box_filter_3x3_unit import bf3_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  // Configuration port.
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  // Item channel.
  input  logic                         item_valid,
  output logic                         item_ready,
  input  logic                         opcode,
  input  logic signed [PIXEL_BITS-1:0] pixel_in,
  // Result channel.
  output logic                         result_valid,
  input  logic                         result_ready,
  output logic signed [PIXEL_BITS-1:0] pixel_out,
  output logic                         frame_last
);

  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  logic [WREG_W-1:0] frame_width;
  logic [HREG_W-1:0] frame_height;
  logic              cfg_write;
  logic              cfg_clear;
  logic [WEFF_W-1:0] width_eff;
  logic [HEFF_W-1:0] height_eff;

  logic  work_push;
  work_t work_in;
  work_t work_head;
  logic  queue_full;
  logic  queue_nonempty;
  logic  work_pop;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  // Both registers are written whole; any write restarts the frame.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RST;
      frame_height <= FRAME_HEIGHT_RST;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_FRAME_WIDTH:  frame_width  <= pwdata[WREG_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= pwdata[HREG_W-1:0];
        default:          frame_width  <= frame_width;
      endcase
    end
  end

  assign cfg_clear = cfg_write;

  always_comb begin
    case (paddr[2])
      REG_FRAME_WIDTH:  prdata = 32'(frame_width);
      REG_FRAME_HEIGHT: prdata = 32'(frame_height);
      default:          prdata = '0;
    endcase
  end

  // Sizes out of range are clamped; zero counts as one.
  always_comb begin
    if (frame_width == '0) begin
      width_eff = WEFF_W'(1);
    end else if (frame_width > WREG_W'(MAX_WIDTH)) begin
      width_eff = WEFF_W'(MAX_WIDTH);
    end else begin
      width_eff = WEFF_W'(frame_width);
    end
    if (frame_height == '0) begin
      height_eff = HEFF_W'(1);
    end else if (frame_height > HREG_W'(MAX_HEIGHT)) begin
      height_eff = HEFF_W'(MAX_HEIGHT);
    end else begin
      height_eff = HEFF_W'(frame_height);
    end
  end

  bf3_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_clear  (cfg_clear),
    .width_eff  (width_eff),
    .height_eff (height_eff),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .opcode     (opcode),
    .pixel_in   (pixel_in),
    .queue_full (queue_full),
    .work_push  (work_push),
    .work       (work_in)
  );

  bf3_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (work_push),
    .push_data (work_in),
    .pop       (work_pop),
    .head      (work_head),
    .full      (queue_full),
    .nonempty  (queue_nonempty)
  );

  logic back_ready;

  assign work_pop = queue_nonempty && back_ready;

  bf3_back u_back (
    .clk          (clk),
    .rst          (rst),
    .work_valid   (queue_nonempty),
    .work         (work_head),
    .work_ready   (back_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .pixel_out    (pixel_out),
    .frame_last   (frame_last)
  );

endmodule
`default_nettype wire
